// File: hw/rtl/otv_pkg.sv
// Shared types, widths and rounding helpers for the three-vector orthonormalizer.
// No dependencies; every other file of the block refers to it by scoped names.
package otv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GUARD     = 7;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 18;
	localparam int RES_W     = 26;                  // residual, |r| <= 2^24
	localparam int EPS_W     = 16;
	localparam int SQ_W      = 64;                  // radicand width
	localparam int ROOT_W    = SQ_W / 2;
	localparam int QUO_W     = FRAC_BITS + 1;       // quotient never exceeds 1.0

	// |uz| > 1/sqrt2 in Q.16 holds exactly when |uz| > 46340
	localparam int PERP_LIM  = 46340;

	localparam logic signed [63:0] ONE_W   = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] RES_LIM = 64'sd1 <<< 24;

	typedef logic signed [IN_W-1:0]  in_t;
	typedef logic signed [OUT_W-1:0] unit_t;
	typedef logic signed [RES_W-1:0] res_t;

	localparam unit_t ONE = unit_t'(ONE_W);

	// divide by 2^FRAC_BITS, round half away from zero
	function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] n);
		logic [63:0] mag;
		mag = n[63] ? 64'(-n) : 64'(n);
		mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return n[63] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [63:0] sat_lim(input logic signed [63:0] x,
			input logic signed [63:0] lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

endpackage

// File: hw/rtl/otv_norm.sv
// Pipelined vector normalizer: squares, digit-by-digit square root, restoring divide.
// Uses otv_pkg; carries an opaque payload alongside with the same latency.
module otv_norm #(
	parameter int PW = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  otv_pkg::res_t                c [3],
	input  logic [otv_pkg::EPS_W-1:0]    eps,
	input  logic [PW-1:0]                pay_in,
	output logic                         out_valid,
	output otv_pkg::unit_t               o [3],
	output logic                         degen,
	output logic [PW-1:0]                pay_out
);
	localparam int SQ_PER  = 2;
	localparam int SQ_STG  = otv_pkg::ROOT_W / SQ_PER;
	localparam int DIV_PER = 2;
	localparam int DIV_STG = (otv_pkg::QUO_W + DIV_PER - 1) / DIV_PER;
	localparam int LAT     = SQ_STG + DIV_STG + 4;
	localparam int SQR_W   = 2 * (otv_pkg::RES_W - 1);
	localparam int NUM_W   = otv_pkg::RES_W + otv_pkg::FRAC_BITS + otv_pkg::GUARD;

	typedef struct packed {
		logic [otv_pkg::SQ_W-1:0] rem;
		logic [otv_pkg::SQ_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [otv_pkg::ROOT_W-1:0] rem;
		logic [otv_pkg::QUO_W-1:0]  low;
		logic [otv_pkg::QUO_W-1:0]  q;
		logic                       neg;
	} dl_t;

	function automatic logic [otv_pkg::RES_W-2:0] mag_of(input otv_pkg::res_t x);
		logic [otv_pkg::RES_W-1:0] t;
		t = x[otv_pkg::RES_W-1] ? -x : x;
		return t[otv_pkg::RES_W-2:0];
	endfunction

	function automatic sq_t sqrt_step(input sq_t x, input logic [otv_pkg::SQ_W-1:0] b);
		sq_t y;
		if (x.rem >= x.root + b) begin
			y.rem  = x.rem - (x.root + b);
			y.root = (x.root >> 1) + b;
		end else begin
			y.rem  = x.rem;
			y.root = x.root >> 1;
		end
		return y;
	endfunction

	function automatic dl_t div_step(input dl_t x, input logic [otv_pkg::ROOT_W-1:0] m);
		dl_t y;
		logic [otv_pkg::ROOT_W:0] t;
		t = {x.rem, x.low[otv_pkg::QUO_W-1]};
		y = x;
		y.low = x.low << 1;
		if (t >= {1'b0, m}) begin
			y.rem = otv_pkg::ROOT_W'(t - {1'b0, m});
			y.q   = {x.q[otv_pkg::QUO_W-2:0], 1'b1};
		end else begin
			y.rem = t[otv_pkg::ROOT_W-1:0];
			y.q   = {x.q[otv_pkg::QUO_W-2:0], 1'b0};
		end
		return y;
	endfunction

	logic            vld_s [LAT];
	logic [PW-1:0]   pay_s [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[0] <= pay_in;
			for (int i = 1; i < LAT; i++)
				pay_s[i] <= pay_s[i-1];
		end
	end

	// squares
	logic [SQR_W-1:0] sq_s1 [3];
	otv_pkg::res_t    c_s1  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= mag_of(c[i]) * mag_of(c[i]);
				c_s1[i]  <= c[i];
			end
		end
	end

	// sum and guard scaling, then the root, two result bits a stage
	sq_t           sq_s [SQ_STG+1];
	otv_pkg::res_t cs_s [SQ_STG+1][3];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].rem  <= (otv_pkg::SQ_W'(sq_s1[0]) + otv_pkg::SQ_W'(sq_s1[1])
					+ otv_pkg::SQ_W'(sq_s1[2])) << (2 * otv_pkg::GUARD);
			sq_s[0].root <= '0;
			cs_s[0]      <= c_s1;
		end
	end

	for (genvar k = 1; k <= SQ_STG; k++) begin : g_sqrt
		sq_t nxt;
		always_comb begin
			nxt = sq_s[k-1];
			for (int j = 0; j < SQ_PER; j++)
				nxt = sqrt_step(nxt, otv_pkg::SQ_W'(1)
						<< (otv_pkg::SQ_W - 2 - 2 * ((k - 1) * SQ_PER + j)));
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k] <= nxt;
				cs_s[k] <= cs_s[k-1];
			end
		end
	end

	// divide setup: numerator |c|*2^23 + M/2, quotient fits QUO_W bits
	dl_t                        dl_s [DIV_STG+1][3];
	logic [otv_pkg::ROOT_W-1:0] m_s  [DIV_STG+1];
	logic                       dg_s [DIV_STG+1];
	logic [otv_pkg::ROOT_W-1:0] m_root;

	assign m_root = sq_s[SQ_STG].root[otv_pkg::ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= m_root;
			dg_s[0] <= m_root[otv_pkg::ROOT_W-1:otv_pkg::GUARD]
					<= (otv_pkg::ROOT_W - otv_pkg::GUARD)'(eps);
			for (int i = 0; i < 3; i++) begin
				dl_s[0][i].rem <= otv_pkg::ROOT_W'(
						((NUM_W'(mag_of(cs_s[SQ_STG][i])) << (otv_pkg::FRAC_BITS + otv_pkg::GUARD))
						+ NUM_W'(m_root >> 1)) >> otv_pkg::QUO_W);
				dl_s[0][i].low <= otv_pkg::QUO_W'(
						(NUM_W'(mag_of(cs_s[SQ_STG][i])) << (otv_pkg::FRAC_BITS + otv_pkg::GUARD))
						+ NUM_W'(m_root >> 1));
				dl_s[0][i].q   <= '0;
				dl_s[0][i].neg <= cs_s[SQ_STG][i][otv_pkg::RES_W-1];
			end
		end
	end

	for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
		dl_t nxt [3];
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				nxt[i] = dl_s[k-1][i];
				for (int j = 0; j < DIV_PER; j++)
					if ((k - 1) * DIV_PER + j < otv_pkg::QUO_W)
						nxt[i] = div_step(nxt[i], m_s[k-1]);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dl_s[k] <= nxt;
				m_s[k]  <= m_s[k-1];
				dg_s[k] <= dg_s[k-1];
			end
		end
	end

	otv_pkg::unit_t o_q [3];
	logic           dg_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dg_q <= dg_s[DIV_STG];
			for (int i = 0; i < 3; i++) begin
				if (m_s[DIV_STG] == '0)
					o_q[i] <= '0;
				else if (dl_s[DIV_STG][i].neg)
					o_q[i] <= -otv_pkg::unit_t'(dl_s[DIV_STG][i].q);
				else
					o_q[i] <= otv_pkg::unit_t'(dl_s[DIV_STG][i].q);
			end
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign pay_out   = pay_s[LAT-1];
	assign o         = o_q;
	assign degen     = dg_q;

endmodule

// File: hw/rtl/otv_proj.sv
// Removes the projections of x on unit vectors a and b, residual clamped to +-2^24.
// Uses otv_pkg rounding helpers; four register stages, payload carried alongside.
module otv_proj #(
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  otv_pkg::unit_t  a [3],
	input  otv_pkg::unit_t  b [3],
	input  otv_pkg::in_t    x [3],
	input  logic [PW-1:0]   pay_in,
	output logic            out_valid,
	output otv_pkg::res_t   r [3],
	output logic [PW-1:0]   pay_out
);
	localparam int LAT  = 4;
	localparam int PR_W = otv_pkg::OUT_W + otv_pkg::IN_W;
	localparam int D_W  = 28;
	localparam int T_W  = D_W + otv_pkg::OUT_W;

	logic          vld_s [LAT];
	logic [PW-1:0] pay_s [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[0] <= pay_in;
			for (int i = 1; i < LAT; i++)
				pay_s[i] <= pay_s[i-1];
		end
	end

	logic signed [PR_W-1:0] pa_s1 [3];
	logic signed [PR_W-1:0] pb_s1 [3];
	otv_pkg::unit_t         a_s1 [3], b_s1 [3], a_s2 [3], b_s2 [3];
	otv_pkg::in_t           x_s1 [3], x_s2 [3], x_s3 [3];
	logic signed [D_W-1:0]  d0_s2, d1_s2;
	logic signed [T_W-1:0]  ta_s3 [3];
	logic signed [T_W-1:0]  tb_s3 [3];
	otv_pkg::res_t          r_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= a[i] * x[i];
				pb_s1[i] <= b[i] * x[i];
			end
			a_s1 <= a;
			b_s1 <= b;
			x_s1 <= x;

			d0_s2 <= D_W'(otv_pkg::rnd_frac(64'(pa_s1[0]) + 64'(pa_s1[1]) + 64'(pa_s1[2])));
			d1_s2 <= D_W'(otv_pkg::rnd_frac(64'(pb_s1[0]) + 64'(pb_s1[1]) + 64'(pb_s1[2])));
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			x_s2  <= x_s1;

			for (int i = 0; i < 3; i++) begin
				ta_s3[i] <= d0_s2 * a_s2[i];
				tb_s3[i] <= d1_s2 * b_s2[i];
			end
			x_s3 <= x_s2;

			for (int i = 0; i < 3; i++)
				r_s4[i] <= otv_pkg::RES_W'(otv_pkg::sat_lim(64'(x_s3[i])
						- otv_pkg::rnd_frac(64'(ta_s3[i]))
						- otv_pkg::rnd_frac(64'(tb_s3[i])), otv_pkg::RES_LIM));
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign pay_out   = pay_s[LAT-1];
	assign r         = r_s4;

endmodule

// File: hw/rtl/otv_cross.sv
// Cross product of two unit vectors, rounded and saturated to +-1.0.
// Uses otv_pkg; two register stages, payload carried alongside.
module otv_cross #(
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  otv_pkg::unit_t  a [3],
	input  otv_pkg::unit_t  b [3],
	input  logic [PW-1:0]   pay_in,
	output logic            out_valid,
	output otv_pkg::unit_t  o [3],
	output logic [PW-1:0]   pay_out
);
	localparam int P_W = 2 * otv_pkg::OUT_W;

	logic                  vld_s1, vld_s2;
	logic [PW-1:0]         pay_s1, pay_s2;
	logic signed [P_W-1:0] p_s1 [6];
	otv_pkg::unit_t        o_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1  <= pay_in;
			pay_s2  <= pay_s1;
			p_s1[0] <= a[1] * b[2];
			p_s1[1] <= a[2] * b[1];
			p_s1[2] <= a[2] * b[0];
			p_s1[3] <= a[0] * b[2];
			p_s1[4] <= a[0] * b[1];
			p_s1[5] <= a[1] * b[0];
			for (int i = 0; i < 3; i++)
				o_s2[i] <= otv_pkg::OUT_W'(otv_pkg::sat_lim(otv_pkg::rnd_frac(
						64'(p_s1[2*i]) - 64'(p_s1[2*i+1])), otv_pkg::ONE_W));
		end
	end

	assign out_valid = vld_s2;
	assign pay_out   = pay_s2;
	assign o         = o_s2;

endmodule

// File: hw/rtl/orthonormalize_three_vectors_top.sv
// Top level of the three-vector orthonormalizer (Gram-Schmidt with fallbacks).
// Uses otv_pkg, otv_norm, otv_proj and otv_cross.
//
// Input stream s_axis: one beat carries u, v, w (nine signed Q8.16 words).
// Output stream m_axis: one beat per input beat, basis u, v, w in signed Q1.16
// and a fallback mask in tuser (bit0 u set to x axis, bit1 v set to a
// perpendicular of u, bit2 w set to u cross v).
// cfg_wr_en/cfg_wr_data write the degeneracy threshold epsilon (Q0.16, reset 1 LSB);
// write it only while no beats are in flight.
// The path runs through three normalizers of 29 stages (16 square-root stages
// at two root bits each, 9 divide stages at two quotient bits each), two
// projection units of 4 stages and a 2-stage cross product.
// Throughput is one beat per cycle while the output is not held. The whole
// pipeline advances together; when m_axis_tready is low with a result waiting,
// every stage holds and s_axis_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits and sets epsilon to 1 LSB; no clearing pass is needed.
module orthonormalize_three_vectors_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z (24 bits each)
	input  logic [215:0]                  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// basis_u_x/y/z, basis_v_x/y/z, basis_w_x/y/z (18 bits each), 6 pad bits
	output logic [167:0]                  m_axis_tdata,
	// fallback_mask
	output logic [2:0]                    m_axis_tuser,
	input  logic                          cfg_wr_en,
	input  logic [otv_pkg::EPS_W-1:0]     cfg_wr_data
);
	typedef struct packed {
		logic w_cross;
		logic v_perp;
		logic u_axis;
	} fb_t;

	typedef struct packed {
		otv_pkg::in_t [2:0] v;
		otv_pkg::in_t [2:0] w;
	} pl_u_t;

	typedef struct packed {
		otv_pkg::unit_t [2:0] uh;
		logic                 fb_u;
		otv_pkg::in_t [2:0]   w;
	} pl_v_t;

	typedef struct packed {
		otv_pkg::unit_t [2:0] uh;
		otv_pkg::unit_t [2:0] vh;
		logic                 fb_u;
		logic                 fb_v;
	} pl_w_t;

	typedef struct packed {
		otv_pkg::unit_t [2:0] uh;
		otv_pkg::unit_t [2:0] vh;
		otv_pkg::unit_t [2:0] wn;
		fb_t                  fb;
	} pl_x_t;

	logic [otv_pkg::EPS_W-1:0] eps_q;
	logic                      en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eps_q <= otv_pkg::EPS_W'(1);
		else if (cfg_wr_en)
			eps_q <= cfg_wr_data;
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	otv_pkg::res_t  u_c [3];
	pl_u_t          pl_u, nu_pay;
	otv_pkg::unit_t nu_o [3];
	logic           nu_valid, nu_dg;

	otv_pkg::unit_t uh_a [3], zero_b [3];
	otv_pkg::in_t   v_x [3];
	pl_v_t          pl_v, pv_pay, nv_pay;
	otv_pkg::res_t  pv_r [3];
	logic           pv_valid;

	logic [otv_pkg::OUT_W-1:0] uz_abs;
	otv_pkg::res_t  perp [3];
	otv_pkg::unit_t nv_o [3], np_o [3];
	logic           nv_valid, nv_dg;

	otv_pkg::unit_t uh_w [3], vh_w [3];
	otv_pkg::in_t   w_x [3];
	pl_w_t          pl_w, pw_pay, nw_pay;
	otv_pkg::res_t  pw_r [3];
	logic           pw_valid;

	otv_pkg::unit_t nw_o [3], cu [3], cv [3], cx_o [3], wh [3];
	logic           nw_valid, nw_dg, cx_valid;
	pl_x_t          pl_x, cx_pay;

	always_comb begin
		pl_u.v = s_axis_tdata[143:72];
		pl_u.w = s_axis_tdata[215:144];
		for (int i = 0; i < 3; i++)
			u_c[i] = otv_pkg::res_t'($signed(s_axis_tdata[24*i +: 24]));

		// u fallback: x axis
		for (int i = 0; i < 3; i++) begin
			if (nu_dg)
				uh_a[i] = (i == 0) ? otv_pkg::ONE : '0;
			else
				uh_a[i] = nu_o[i];
			zero_b[i]  = '0;
			v_x[i]     = nu_pay.v[i];
			pl_v.uh[i] = uh_a[i];
		end
		pl_v.fb_u = nu_dg;
		pl_v.w    = nu_pay.w;

		// perpendicular of u: y-z plane when |uz| > 1/sqrt2
		uz_abs = pv_pay.uh[2][otv_pkg::OUT_W-1] ? -pv_pay.uh[2] : pv_pay.uh[2];
		if (uz_abs > otv_pkg::OUT_W'(otv_pkg::PERP_LIM)) begin
			perp[0] = '0;
			perp[1] = -otv_pkg::res_t'($signed(pv_pay.uh[2]));
			perp[2] = otv_pkg::res_t'($signed(pv_pay.uh[1]));
		end else begin
			perp[0] = -otv_pkg::res_t'($signed(pv_pay.uh[1]));
			perp[1] = otv_pkg::res_t'($signed(pv_pay.uh[0]));
			perp[2] = '0;
		end

		for (int i = 0; i < 3; i++) begin
			uh_w[i]    = nv_pay.uh[i];
			vh_w[i]    = nv_dg ? np_o[i] : nv_o[i];
			w_x[i]     = nv_pay.w[i];
			pl_w.uh[i] = uh_w[i];
			pl_w.vh[i] = vh_w[i];
		end
		pl_w.fb_u = nv_pay.fb_u;
		pl_w.fb_v = nv_dg;

		for (int i = 0; i < 3; i++) begin
			cu[i]      = nw_pay.uh[i];
			cv[i]      = nw_pay.vh[i];
			pl_x.uh[i] = nw_pay.uh[i];
			pl_x.vh[i] = nw_pay.vh[i];
			pl_x.wn[i] = nw_o[i];
		end
		pl_x.fb.u_axis  = nw_pay.fb_u;
		pl_x.fb.v_perp  = nw_pay.fb_v;
		pl_x.fb.w_cross = nw_dg;

		for (int i = 0; i < 3; i++)
			wh[i] = cx_pay.fb.w_cross ? cx_o[i] : cx_pay.wn[i];
	end

	otv_norm #(.PW($bits(pl_u_t))) u_norm_u (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_axis_tvalid),
		.c(u_c), .eps(eps_q), .pay_in(pl_u),
		.out_valid(nu_valid), .o(nu_o), .degen(nu_dg), .pay_out(nu_pay)
	);

	otv_proj #(.PW($bits(pl_v_t))) u_proj_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(nu_valid),
		.a(uh_a), .b(zero_b), .x(v_x), .pay_in(pl_v),
		.out_valid(pv_valid), .r(pv_r), .pay_out(pv_pay)
	);

	otv_norm #(.PW($bits(pl_v_t))) u_norm_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pv_valid),
		.c(pv_r), .eps(eps_q), .pay_in(pv_pay),
		.out_valid(nv_valid), .o(nv_o), .degen(nv_dg), .pay_out(nv_pay)
	);

	// runs in step with u_norm_v; only its vector is used
	otv_norm #(.PW(1)) u_norm_perp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pv_valid),
		.c(perp), .eps(eps_q), .pay_in(1'b0),
		.out_valid(), .o(np_o), .degen(), .pay_out()
	);

	otv_proj #(.PW($bits(pl_w_t))) u_proj_w (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(nv_valid),
		.a(uh_w), .b(vh_w), .x(w_x), .pay_in(pl_w),
		.out_valid(pw_valid), .r(pw_r), .pay_out(pw_pay)
	);

	otv_norm #(.PW($bits(pl_w_t))) u_norm_w (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pw_valid),
		.c(pw_r), .eps(eps_q), .pay_in(pw_pay),
		.out_valid(nw_valid), .o(nw_o), .degen(nw_dg), .pay_out(nw_pay)
	);

	otv_cross #(.PW($bits(pl_x_t))) u_cross (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(nw_valid),
		.a(cu), .b(cv), .pay_in(pl_x),
		.out_valid(cx_valid), .o(cx_o), .pay_out(cx_pay)
	);

	assign m_axis_tvalid = cx_valid;
	assign m_axis_tuser  = cx_pay.fb;
	assign m_axis_tdata  = {6'b0, wh[2], wh[1], wh[0],
			cx_pay.vh[2], cx_pay.vh[1], cx_pay.vh[0],
			cx_pay.uh[2], cx_pay.uh[1], cx_pay.uh[0]};

`ifndef SYNTHESIS
	a_u_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[17:0] == 18'h10000 && m_axis_tdata[35:18] == 18'h0
			&& m_axis_tdata[53:36] == 18'h0)
		else $error("u fallback beat is not the x axis");

	a_v_perp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tdata[71:54] == 18'h0 || m_axis_tdata[107:90] == 18'h0)
		else $error("v fallback beat has no zero component");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			$signed(m_axis_tdata[17:0]) <= 18'sd65536
			&& $signed(m_axis_tdata[17:0]) >= -18'sd65536
			&& $signed(m_axis_tdata[161:144]) <= 18'sd65536
			&& $signed(m_axis_tdata[161:144]) >= -18'sd65536)
		else $error("basis component beyond unit range");
`endif

endmodule
